[rtl/dsfp_pkg.sv]
// ============================================================================
// dsfp_pkg: shared types and constants of the dithered float to PCM16 core
// Holds the LCG step, the lane control bundle and the format constants.
// ============================================================================
package dsfp_pkg;

    // Noise generator: 31-bit linear congruential generator
    localparam logic [30:0] SEED_RESET = 31'h16BA2118;
    localparam logic [30:0] LCG_MUL    = 31'd1103515245;
    localparam logic [30:0] LCG_ADD    = 31'd12345;

    // Single-precision exponent landmarks
    localparam logic [7:0] EXP_SPECIAL = 8'hFF;   // infinity or NaN
    localparam logic [7:0] EXP_SAT     = 8'd143;  // magnitude 2^16 and above
    localparam logic [7:0] EXP_BASE    = 8'd117;  // mantissa LSB weighs 2^-33
    localparam logic [7:0] SHIFT_CAP   = 8'd24;   // right shift that empties the mantissa

    // Fixed-point widths (33 fraction bits)
    localparam int MAG_W  = 49;
    localparam int SUM_W  = 51;
    localparam int FRAC_W = 31;

    // PCM16 limits and the offset that undoes the rounding bias
    localparam logic signed [15:0] PCM_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] PCM_MIN  = 16'sh8000;
    localparam logic signed [19:0] Q_OFFSET = 20'sd131072;
    localparam logic signed [19:0] R_MAX    = 20'sd32767;
    localparam logic signed [19:0] R_MIN    = -20'sd32768;

    // Load strobes for the two registered stages of every lane
    typedef struct packed {
        logic ld1;
        logic ld2;
    } t_lane_ctl;

    // One generator step, modulo 2^31
    function automatic logic [30:0] lcg_next(input logic [30:0] s);
        logic [30:0] p;
        p = s * LCG_MUL;
        return p + LCG_ADD;
    endfunction

endpackage

[rtl/dsfp_seed.sv]
// ============================================================================
// dsfp_seed: dither noise generator
// Holds the 31-bit seed and steps it through one shared LCG multiplier.
// ============================================================================
module dsfp_seed (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    output logic [30:0] o_seed,
    output logic [30:0] o_seed_next
);
    import dsfp_pkg::*;

    logic [30:0] r_seed;
    logic [30:0] n_seed;
    logic [30:0] w_next;

    // The single multiplier of the block
    assign w_next = lcg_next(r_seed);

    always_comb begin
        n_seed = r_seed;
        if (i_step) begin
            n_seed = w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else begin
            r_seed <= n_seed;
        end
    end

    assign o_seed      = r_seed;
    assign o_seed_next = w_next;

    // A step replaces the seed by its successor; otherwise it holds.
    a_step_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_seed == lcg_next($past(r_seed)))
        else $error("seed did not advance by one generator step");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_seed))
        else $error("seed changed without a step");

endmodule

[rtl/dsfp_lane.sv]
// ============================================================================
// dsfp_lane: one channel converter
// Aligns a float to 33 fraction bits, adds dither, rounds half to even and
// saturates to PCM16. Two registered stages, rounding feeds the merge stage.
// ============================================================================
module dsfp_lane (
    input  logic                 i_clk,
    input  dsfp_pkg::t_lane_ctl  i_ctl,
    input  logic [31:0]          i_sample,
    input  logic [30:0]          i_frac,
    output logic [15:0]          o_pcm
);
    import dsfp_pkg::*;

    // Stage 1 decode and alignment
    logic               w_sign;
    logic [7:0]         w_ex;
    logic [22:0]        w_man;
    logic               w_nan;
    logic               w_sat;
    logic [23:0]        w_m;
    logic [7:0]         w_exe;
    logic [7:0]         w_rdist;
    logic [4:0]         w_sh;
    logic [23:0]        w_mask;
    logic               w_lost;
    logic [MAG_W-1:0]   w_mag;

    logic               r1_sign;
    logic               r1_nan;
    logic               r1_sat;
    logic [MAG_W-1:0]   r1_mag;
    logic [FRAC_W-1:0]  r1_frac;

    // Stage 2 signed add of dither
    logic [SUM_W-1:0]   w_smag;
    logic [SUM_W-1:0]   w_sum;
    logic [SUM_W-1:0]   w_u;

    logic               r2_sign;
    logic               r2_nan;
    logic               r2_sat;
    logic [SUM_W-1:0]   r2_u;

    // Rounding and saturation
    logic [17:0]        w_q;
    logic [32:0]        w_rem;
    logic               w_up;
    logic [18:0]        w_qr;
    logic signed [19:0] w_r;

    // Split the float and place its mantissa at a 2^-33 grid, with the
    // shifted-out bits jammed into the LSB.
    always_comb begin
        w_sign  = i_sample[31];
        w_ex    = i_sample[30:23];
        w_man   = i_sample[22:0];
        w_nan   = (w_ex == EXP_SPECIAL) && (w_man != 23'd0);
        w_sat   = (w_ex >= EXP_SAT);
        w_m     = {(w_ex != 8'd0), w_man};
        w_exe   = (w_ex == 8'd0) ? 8'd1 : w_ex;
        w_rdist = EXP_BASE - w_exe;
        w_sh    = 5'd0;
        w_mask  = 24'd0;
        w_lost  = 1'b0;
        if (w_exe >= EXP_BASE) begin
            w_sh  = 5'(w_exe - EXP_BASE);
            w_mag = {25'd0, w_m} << w_sh;
        end else begin
            w_sh   = (w_rdist > SHIFT_CAP) ? 5'(SHIFT_CAP) : w_rdist[4:0];
            w_mask = 24'((25'd1 << w_sh) - 25'd1);
            w_lost = |(w_m & w_mask);
            w_mag  = {25'd0, (w_m >> w_sh)} | {48'd0, w_lost};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r1_sign <= w_sign;
            r1_nan  <= w_nan;
            r1_sat  <= w_sat;
            r1_mag  <= w_mag;
            r1_frac <= i_frac;
        end
    end

    // Signed value plus dither, then the 2^50 bias by flipping the top bit.
    always_comb begin
        w_smag = r1_sign ? ({SUM_W{1'b0}} - {2'd0, r1_mag}) : {2'd0, r1_mag};
        w_sum  = w_smag + {18'd0, r1_frac, 2'd0};
        w_u    = {~w_sum[SUM_W-1], w_sum[SUM_W-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r2_sign <= r1_sign;
            r2_nan  <= r1_nan;
            r2_sat  <= r1_sat;
            r2_u    <= w_u;
        end
    end

    // Round half to even, remove the bias and clamp; specials take priority.
    always_comb begin
        w_q   = r2_u[50:33];
        w_rem = r2_u[32:0];
        w_up  = w_rem[32] && ((w_rem[31:0] != 32'd0) || w_q[0]);
        w_qr  = {1'b0, w_q} + {18'd0, w_up};
        w_r   = $signed({1'b0, w_qr}) - Q_OFFSET;
        if (r2_nan) begin
            o_pcm = 16'd0;
        end else if (r2_sat) begin
            o_pcm = r2_sign ? PCM_MIN : PCM_MAX;
        end else if (w_r < R_MIN) begin
            o_pcm = PCM_MIN;
        end else if (w_r > R_MAX) begin
            o_pcm = PCM_MAX;
        end else begin
            o_pcm = w_r[15:0];
        end
    end

endmodule

[rtl/dsfp_merge.sv]
// ============================================================================
// dsfp_merge: lane merge and output register
// Packs the two channel results into one PCM word and holds it for the sink.
// ============================================================================
module dsfp_merge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [15:0] i_right,
    input  logic [15:0] i_left,
    input  logic        i_last,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [31:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic        o_free
);
    logic        r_valid;
    logic        n_valid;
    logic [31:0] r_data;
    logic        r_last;

    // The register can take a new item when empty or when the sink takes it.
    assign o_free = !r_valid || i_m_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Right channel in the upper half, left in the lower half.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= {i_right, i_left};
            r_last <= i_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;

endmodule

[rtl/dithered_stereo_float_to_pcm16_core.sv]
// Flow: an accepted frame moves from stage 0 through the registered lane stages into
// the merge output register. Stage 0 takes a new frame only after the last one left it.
// With dither on, the shared LCG multiplier steps the seed twice per frame, once at
// acceptance and once as the frame enters the lanes.
// Reset: synchronous, active low; the seed returns to 0x16BA2118, dither is on,
// and all stages are empty.
// ============================================================================
// dithered_stereo_float_to_pcm16_core: stereo float to PCM16 with dither
// Two converter lanes run side by side on the right and left samples, fed by
// one noise generator, and a merge stage packs their results.
// ============================================================================
module dithered_stereo_float_to_pcm16_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: dither_enable
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] left_sample, [63:32] right_sample
    input  logic        i_s_tlast,   // last_frame
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] packed_frame
    output logic        o_m_tlast    // frame_is_last
);
    import dsfp_pkg::*;

    logic        r_dither_en;
    logic        r_v0;
    logic        n_v0;
    logic        r_v1;
    logic        n_v1;
    logic        r_v2;
    logic        n_v2;
    logic [31:0] r0_left;
    logic [31:0] r0_right;
    logic        r0_last;
    logic        r1_last;
    logic        r2_last;

    logic        w_s_acc;
    logic        w_out_free;
    logic        w_acc2;
    logic        w_adv2;
    logic        w_acc1;
    logic        w_mv1;
    logic        w_mv0;
    logic        w_step;
    logic [30:0] w_seed;
    logic [30:0] w_seed_next;
    logic [30:0] w_frac_r;
    logic [30:0] w_frac_l;
    logic [15:0] w_pcm_r;
    logic [15:0] w_pcm_l;
    t_lane_ctl   w_ctl;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dither_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_dither_en <= i_cfg_data[0];
        end
    end

    // Stage 0 holds a frame for the second noise step, so it takes a new
    // item only when empty.
    assign o_s_tready = !r_v0;
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    // Elastic pipeline advance from the output backward
    assign w_acc2 = !r_v2 || w_out_free;
    assign w_adv2 = r_v2 && w_out_free;
    assign w_acc1 = !r_v1 || w_acc2;
    assign w_mv1  = r_v1 && w_acc2;
    assign w_mv0  = r_v0 && w_acc1;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_v2 = r_v2;
        if (w_s_acc) begin
            n_v0 = 1'b1;
        end else if (w_mv0) begin
            n_v0 = 1'b0;
        end
        if (w_mv0) begin
            n_v1 = 1'b1;
        end else if (w_mv1) begin
            n_v1 = 1'b0;
        end
        if (w_mv1) begin
            n_v2 = 1'b1;
        end else if (w_adv2) begin
            n_v2 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    // Frame payload and its last flag along the stages
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r0_left  <= i_s_tdata[31:0];
            r0_right <= i_s_tdata[63:32];
            r0_last  <= i_s_tlast;
        end
        if (w_mv0) begin
            r1_last <= r0_last;
        end
        if (w_mv1) begin
            r2_last <= r1_last;
        end
    end

    // Noise: first step at acceptance gives the right fraction, the second
    // as the frame enters the lanes gives the left fraction.
    assign w_step = r_dither_en && (w_s_acc || w_mv0);

    dsfp_seed u_seed (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .o_seed      (w_seed),
        .o_seed_next (w_seed_next)
    );

    assign w_frac_r = r_dither_en ? w_seed      : 31'd0;
    assign w_frac_l = r_dither_en ? w_seed_next : 31'd0;

    assign w_ctl.ld1 = w_mv0;
    assign w_ctl.ld2 = w_mv1;

    // Two converter lanes
    dsfp_lane u_lane_r (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (r0_right),
        .i_frac   (w_frac_r),
        .o_pcm    (w_pcm_r)
    );

    dsfp_lane u_lane_l (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (r0_left),
        .i_frac   (w_frac_l),
        .o_pcm    (w_pcm_l)
    );

    // Merge and output register
    dsfp_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_adv2),
        .i_right    (w_pcm_r),
        .i_left     (w_pcm_l),
        .i_last     (r2_last),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_free     (w_out_free)
    );

    // An accepted item occupies stage 0 and blocks the next one.
    a_accept_fills_s0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> r_v0 && !o_s_tready)
        else $error("accepted item did not occupy stage 0");

    // A stalled stage 1 item is never dropped.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !w_acc2 |=> r_v1)
        else $error("stage 1 item lost under stall");

    // An item moving out of stage 1 always lands in stage 2.
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mv1 |=> r_v2)
        else $error("item lost between stage 1 and stage 2");

endmodule

[tb/sv/dithered_stereo_float_to_pcm16_checker.sv]
// ============================================================================
// dithered_stereo_float_to_pcm16_checker: result checker for the PCM16 core
// Watches the configuration, input and output channels of the converter. It
// keeps its own noise seed and dither setting, predicts the packed PCM16 word
// of every accepted frame, and compares each output item with the oldest
// prediction.
// ============================================================================
module dithered_stereo_float_to_pcm16_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [0:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] left_sample, [63:32] right_sample
    input  logic        i_s_tlast,   // last_frame
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [31:0] packed_frame
    input  logic        i_m_tlast,   // frame_is_last
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam logic [30:0] SEED_INIT  = 31'h16BA2118;
    localparam logic [63:0] NOISE_MUL  = 64'd1103515245;
    localparam logic [63:0] NOISE_INC  = 64'd12345;
    localparam logic [63:0] ROUND_BIAS = 64'd1 << 50;
    localparam logic [63:0] HALF_LSB   = 64'd1 << 32;
    localparam logic [63:0] FRAC_MASK  = (64'd1 << 33) - 64'd1;

    typedef struct packed {
        logic [31:0] packed_frame;
        logic        frame_is_last;
    } t_pcm_frame;

    t_pcm_frame        expected_frames [$];
    t_pcm_frame        want;
    logic [30:0]       noise_seed;
    logic              dither_on;
    logic [32:0]       right_frac;
    logic [32:0]       left_frac;
    logic signed [15:0] right_pcm;
    logic signed [15:0] left_pcm;
    int                errors;
    int                compared;

    // One step of the 31-bit noise generator.
    function automatic logic [30:0] noise_step(input logic [30:0] s);
        logic [63:0] p;
        p = {33'd0, s} * NOISE_MUL + NOISE_INC;
        return p[30:0];
    endfunction

    // Float sample plus a dither fraction in units of 2^-33, rounded to
    // nearest with ties to even, then clamped to the PCM16 range.
    function automatic logic signed [15:0] float_to_pcm16(input logic [31:0] bits,
                                                          input logic [32:0] frac);
        logic               sgn;
        logic [7:0]         expo;
        logic [22:0]        mant;
        logic [63:0]        sig;
        logic [63:0]        mag;
        logic [63:0]        lost_mask;
        logic [63:0]        sum;
        logic [63:0]        quo;
        logic [63:0]        rem;
        logic signed [63:0] rounded;
        int unsigned        shift;
        sgn  = bits[31];
        expo = bits[30:23];
        mant = bits[22:0];
        if (expo == 8'hFF && mant != 23'd0) begin
            return 16'sd0;
        end
        if (expo >= 8'd143) begin
            return sgn ? 16'sh8000 : 16'sh7FFF;
        end
        if (expo == 8'd0) begin
            sig  = {41'd0, mant};
            expo = 8'd1;
        end else begin
            sig = {40'd0, 1'b1, mant};
        end
        // Tiny values lose bits below 2^-33; any lost bit survives as a sticky LSB.
        if (expo >= 8'd117) begin
            mag = sig << (expo - 8'd117);
        end else begin
            shift     = 117 - expo;
            lost_mask = (64'd1 << shift) - 64'd1;
            mag       = (sig >> shift) | {63'd0, |(sig & lost_mask)};
        end
        sum = (sgn ? (64'd0 - mag) : mag) + {31'd0, frac} + ROUND_BIAS;
        quo = sum >> 33;
        rem = sum & FRAC_MASK;
        if (rem > HALF_LSB || (rem == HALF_LSB && quo[0])) begin
            quo = quo + 64'd1;
        end
        rounded = $signed(quo) - 64'sd131072;
        if (rounded < -64'sd32768) begin
            return 16'sh8000;
        end
        if (rounded > 64'sd32767) begin
            return 16'sh7FFF;
        end
        return rounded[15:0];
    endfunction

    // Track the setting, predict accepted frames and check output items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            noise_seed = SEED_INIT;
            dither_on  = 1'b1;
            expected_frames.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                dither_on = i_cfg_data[0];
            end

            // Outputs are checked before the new frame is queued, since a frame
            // cannot leave at the edge that accepts it.
            if (i_m_tvalid && i_m_tready) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected item: expected none, got tdata %08h tlast %0b",
                             $time, i_m_tdata, i_m_tlast);
                    errors++;
                end else begin
                    want = expected_frames.pop_front();
                    compared++;
                    if (i_m_tdata !== want.packed_frame) begin
                        $display("%0t: packed_frame mismatch: expected %08h, got %08h",
                                 $time, want.packed_frame, i_m_tdata);
                        errors++;
                    end
                    if (i_m_tlast !== want.frame_is_last) begin
                        $display("%0t: frame_is_last mismatch: expected %0b, got %0b",
                                 $time, want.frame_is_last, i_m_tlast);
                        errors++;
                    end
                end
            end

            // The right channel takes the first noise value, the left the second.
            if (i_s_tvalid && i_s_tready) begin
                right_frac = 33'd0;
                left_frac  = 33'd0;
                if (dither_on) begin
                    noise_seed = noise_step(noise_seed);
                    right_frac = {noise_seed, 2'b00};
                    noise_seed = noise_step(noise_seed);
                    left_frac  = {noise_seed, 2'b00};
                end
                right_pcm = float_to_pcm16(i_s_tdata[63:32], right_frac);
                left_pcm  = float_to_pcm16(i_s_tdata[31:0], left_frac);
                want.packed_frame  = {right_pcm, left_pcm};
                want.frame_is_last = i_s_tlast;
                expected_frames.push_back(want);
            end

            o_pending <= expected_frames.size();
        end
        o_fail_count <= errors;
        o_checked    <= compared;
    end

endmodule

[tb/sv/dithered_stereo_float_to_pcm16_core_tb.sv]
// ============================================================================
// dithered_stereo_float_to_pcm16_core_tb: testbench of the PCM16 core
// Drives stereo float frames into the core with bursty pacing while the output
// side stalls on its own pattern. Edge values run first with dither on and
// off, then random frames over several dither settings. A checker beside the
// core predicts and compares every output item.
// ============================================================================
module dithered_stereo_float_to_pcm16_core_tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 6;
    localparam int PHASE_FRAMES = 400;

    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_HOLDOFF,
        RX_TOGGLE
    } t_rx_mode;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = 64'd0;   // [31:0] left_sample, [63:32] right_sample
    logic        s_tlast   = 1'b0;    // last_frame
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;             // [31:0] packed_frame
    logic        m_tlast;             // frame_is_last

    int fail_count;
    int pending;
    int checked;
    int frames_sent;
    int dithered_frames;
    int setting_writes;
    int burst_left;
    logic dither_now = 1'b1;
    logic [0:0] dither_plan [5] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    // Extremes, rounding ties, saturation edges, specials and tiny values.
    logic [31:0] edge_values [24] = '{
        32'h0000_0000, 32'h8000_0000,   // +0, -0
        32'h3F00_0000, 32'hBF00_0000,   // 0.5, -0.5
        32'h3FC0_0000, 32'hC020_0000,   // 1.5, -2.5
        32'h4020_0000, 32'hBFC0_0000,   // 2.5, -1.5
        32'h46FF_FE00, 32'hC700_0000,   // 32767, -32768
        32'h46FF_FF00, 32'hC700_0080,   // 32767.5, -32768.5
        32'h477F_FFFF, 32'hC700_0100,   // just under 2^16, -32769
        32'h4780_0000, 32'hFF7F_FFFF,   // 2^16, most negative finite
        32'h7F80_0000, 32'hFF80_0000,   // +infinity, -infinity
        32'h7FC0_0000, 32'hFF80_0001,   // quiet NaN, signed NaN
        32'h0000_0001, 32'h807F_FFFF,   // smallest positive, largest negative subnormal
        32'h3A80_0000, 32'h3A7F_FFFF    // 2^-10 and just below it
    };

    dithered_stereo_float_to_pcm16_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    dithered_stereo_float_to_pcm16_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Clock with a period of 4.
    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // Output side: the stall pattern switches to a new random mode after each random span.
    initial begin : rx_pattern
        t_rx_mode mode;
        int       span;
        int       hold;
        hold = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(16, 200);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    RX_OPEN: begin
                        m_tready <= 1'b1;
                    end
                    RX_COIN: begin
                        m_tready <= 1'($urandom_range(0, 1));
                    end
                    RX_HOLDOFF: begin
                        if (hold == 0) begin
                            m_tready <= 1'b1;
                            hold = $urandom_range(0, 12);
                        end else begin
                            m_tready <= 1'b0;
                            hold--;
                        end
                    end
                    default: begin
                        m_tready <= ~m_tready;
                    end
                endcase
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any handshake.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, pending);
        $display("FAIL dithered_stereo_float_to_pcm16_core");
        $finish;
    end

    // Random float bit pattern, weighted toward values that land in range.
    function automatic logic [31:0] rand_sample();
        logic        neg;
        logic [31:0] steps;
        int          msb;
        int          pick;
        neg  = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: begin
                return {neg, 8'($urandom_range(117, 142)), 23'($urandom)};
            end
            3, 4: begin
                // Whole and half values, so ties and the clamp edges come up often.
                steps = $urandom_range(0, 70000);
                msb   = 0;
                for (int b = 0; b < 17; b++) begin
                    if (steps[b]) begin
                        msb = b;
                    end
                end
                if (steps == 32'd0) begin
                    return {neg, 31'd0};
                end
                return {neg, 8'(126 + msb), 23'((steps << (23 - msb)) & 32'h007F_FFFF)};
            end
            5: begin
                return {neg, 8'($urandom_range(0, 116)), 23'($urandom)};
            end
            6: begin
                return {neg, 8'($urandom_range(143, 254)), 23'($urandom)};
            end
            7: begin
                return {neg, 8'hFF, ($urandom_range(0, 1) != 0) ? 23'd0 : 23'($urandom)};
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // Hold off new items until every predicted result has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Offer one frame, wait for it to be taken, then pace the next one.
    task automatic send_frame(input logic [31:0] left, input logic [31:0] right,
                              input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        frames_sent++;
        if (dither_now) begin
            dithered_frames++;
        end
        if ($urandom_range(0, 149) == 0) begin
            drain();
        end else if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
    endtask

    // Change the dither setting while the core is idle.
    task automatic set_dither(input logic enable);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= enable;
        @(posedge i_clk);
        while (!cfg_ready) begin
            @(posedge i_clk);
        end
        cfg_valid  <= 1'b0;
        dither_now = enable;
        setting_writes++;
    endtask

    // Edge values in pairs; swapped puts each value on the other channel.
    task automatic run_edge_pass(input logic swapped);
        for (int k = 0; k < 12; k++) begin
            if (swapped) begin
                send_frame(edge_values[2 * k + 1], edge_values[2 * k], 1'(k % 3 == 2));
            end else begin
                send_frame(edge_values[2 * k], edge_values[2 * k + 1], 1'(k % 3 == 2));
            end
        end
    endtask

    // Reset, directed edge values, then random phases over several settings.
    initial begin
        burst_left = $urandom_range(1, 20);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Dither is on out of reset, so the first pass also checks the seed.
        run_edge_pass(1'b0);
        set_dither(1'b0);
        run_edge_pass(1'b1);

        for (int p = 0; p < 5; p++) begin
            set_dither(dither_plan[p]);
            repeat (PHASE_FRAMES) begin
                send_frame(rand_sample(), rand_sample(), 1'($urandom_range(0, 7) == 0));
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        $display("Sent %0d frames (%0d dithered) across %0d dither setting writes;",
                 frames_sent, dithered_frames, setting_writes);
        $display("%0d packed results compared, with bursty input and stalled output.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS dithered_stereo_float_to_pcm16_core");
        end else begin
            $display("FAIL dithered_stereo_float_to_pcm16_core");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/dsfp_pkg.sv
rtl/dsfp_seed.sv
rtl/dsfp_lane.sv
rtl/dsfp_merge.sv
rtl/dithered_stereo_float_to_pcm16_core.sv
tb/sv/dithered_stereo_float_to_pcm16_checker.sv
tb/sv/dithered_stereo_float_to_pcm16_core_tb.sv
